// ===== src/vcrp_pkg.sv =====
package vcrp_pkg;

  localparam int OAM_BYTES_DEF     = 256;
  localparam int PALETTE_BYTES_DEF = 32;

  // Bus operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register indexes
  localparam logic [3:0] REG_CONTROL = 4'd0;
  localparam logic [3:0] REG_MASK    = 4'd1;
  localparam logic [3:0] REG_STATUS  = 4'd2;
  localparam logic [3:0] REG_OAMADDR = 4'd3;
  localparam logic [3:0] REG_OAMDATA = 4'd4;
  localparam logic [3:0] REG_SCROLL  = 4'd5;
  localparam logic [3:0] REG_ADDR    = 4'd6;
  localparam logic [3:0] REG_DATA    = 4'd7;
  localparam logic [3:0] REG_DMA     = 4'd8;

  // External access codes
  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_WRITE = 2'd2;

  // VRAM map boundaries
  localparam logic [15:0] EXT_LIMIT    = 16'h3000;
  localparam logic [7:0]  PALETTE_PAGE = 8'h3F;

  typedef struct packed {
    logic       op;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] mem_byte;
    logic       hit_flag;
    logic       overflow_flag;
    logic       vblank_flag;
  } vcrp_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  mem_access;
    logic [13:0] mem_address;
    logic        bad_address;
    logic [14:0] scroll_latch;
    logic [2:0]  fine_scroll_x;
    logic        scroll_update;
    logic        dma_request;
    logic [7:0]  dma_page;
    logic [7:0]  control_bits;
    logic [3:0]  mask_bits;
  } vcrp_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture request, start sprite memory read
    logic commit;  // update state, load result register
  } vcrp_cmd_t;

  function automatic logic [7:0] vcrp_default_palette(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0, 5'd4, 5'd8, 5'd12,
      5'd16, 5'd20, 5'd24, 5'd28: v = 8'h0F;
      5'd1:  v = 8'h31;
      5'd2:  v = 8'h32;
      5'd3:  v = 8'h33;
      5'd5:  v = 8'h35;
      5'd6:  v = 8'h36;
      5'd7:  v = 8'h37;
      5'd9:  v = 8'h39;
      5'd10: v = 8'h3A;
      5'd11: v = 8'h3B;
      5'd13: v = 8'h3D;
      5'd14: v = 8'h3E;
      5'd15: v = 8'h3F;
      5'd17, 5'd25: v = 8'h1C;
      5'd18, 5'd26: v = 8'h15;
      5'd19, 5'd27: v = 8'h14;
      5'd21, 5'd29: v = 8'h02;
      5'd22, 5'd30: v = 8'h38;
      5'd23, 5'd31: v = 8'h3C;
      default: v = 8'h0F;
    endcase
    return v;
  endfunction

endpackage

// ===== src/vcrp_ctrl.sv =====
module vcrp_ctrl
  import vcrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output vcrp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign in_ready   = (state == S_IDLE);
  assign slot_free  = !out_valid || out_ready;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state == S_EXEC) && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd.load) state_next = S_EXEC;
      S_EXEC: if (cmd.commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC) && !in_ready)
    else $error("accepted request did not move to execute");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule

// ===== src/vcrp_datapath.sv =====
module vcrp_datapath
  import vcrp_pkg::*;
#(
  parameter int OAM_BYTES     = OAM_BYTES_DEF,
  parameter int PALETTE_BYTES = PALETTE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  vcrp_cmd_t cmd,
  input  vcrp_in_t  in_data,
  output vcrp_out_t out_data
);

  localparam int OAM_AW = $clog2(OAM_BYTES);
  localparam int PAL_AW = $clog2(PALETTE_BYTES);

  vcrp_in_t  req;
  vcrp_out_t out_q;
  vcrp_out_t res;

  logic [14:0] scroll_t, scroll_t_next;
  logic [15:0] vram_addr, vram_addr_next;
  logic        write_toggle, write_toggle_next;
  logic [2:0]  fine_x, fine_x_next;
  logic [7:0]  control_reg, control_reg_next;
  logic [3:0]  mask_reg, mask_reg_next;
  logic [7:0]  oam_pointer, oam_pointer_next;
  logic [7:0]  data_buffer, data_buffer_next;
  logic [7:0]  dma_page_reg, dma_page_reg_next;

  logic [7:0]           sprite_mem [OAM_BYTES];
  logic [OAM_BYTES-1:0] oam_valid;
  logic [7:0]           oam_rdata;
  logic                 oam_rvalid;
  logic                 sprite_we;

  logic [7:0] palette [PALETTE_BYTES];
  logic       palette_we;
  logic [4:0] pal_slot;

  logic [15:0] inc;
  logic        region_ext;
  logic        region_pal;

  assign inc        = control_reg[2] ? 16'd32 : 16'd1;
  assign region_ext = vram_addr < EXT_LIMIT;
  assign region_pal = vram_addr[15:8] == PALETTE_PAGE;

  // Fold sprite backdrop entries onto the background ones
  always_comb begin
    pal_slot = vram_addr[4:0];
    if ((pal_slot & 5'h13) == 5'h10) pal_slot = pal_slot & 5'h0F;
  end

  always_comb begin
    scroll_t_next     = scroll_t;
    vram_addr_next    = vram_addr;
    write_toggle_next = write_toggle;
    fine_x_next       = fine_x;
    control_reg_next  = control_reg;
    mask_reg_next     = mask_reg;
    oam_pointer_next  = oam_pointer;
    data_buffer_next  = data_buffer;
    dma_page_reg_next = dma_page_reg;
    sprite_we         = 1'b0;
    palette_we        = 1'b0;
    res               = '0;

    if (req.op == OP_READ) begin
      case (req.reg_index)
        REG_STATUS: begin
          res.read_data     = {req.vblank_flag, req.hit_flag, req.overflow_flag, 5'b0};
          write_toggle_next = 1'b0;
        end
        REG_OAMDATA: res.read_data = oam_rvalid ? oam_rdata : 8'h00;
        REG_DATA: begin
          res.read_data = data_buffer;
          if (region_ext) begin
            res.mem_access   = ACC_READ;
            res.mem_address  = vram_addr[13:0];
            data_buffer_next = req.mem_byte;
          end else if (region_pal) begin
            res.read_data = palette[pal_slot[PAL_AW-1:0]];
          end else begin
            res.bad_address = 1'b1;
          end
          vram_addr_next = vram_addr + inc;
        end
        default: ;
      endcase
    end else begin
      case (req.reg_index)
        REG_CONTROL: begin
          control_reg_next = req.write_data;
          scroll_t_next    = {scroll_t[14:12], req.write_data[1:0], scroll_t[9:0]};
        end
        REG_MASK:    mask_reg_next = req.write_data[4:1];
        REG_OAMADDR: oam_pointer_next = req.write_data;
        REG_OAMDATA: begin
          sprite_we        = 1'b1;
          oam_pointer_next = oam_pointer + 8'd1;
        end
        REG_SCROLL: begin
          if (!write_toggle) begin
            scroll_t_next     = {scroll_t[14:5], req.write_data[7:3]};
            fine_x_next       = req.write_data[2:0];
            write_toggle_next = 1'b1;
          end else begin
            scroll_t_next     = {req.write_data[2:0], scroll_t[11:10],
                                 req.write_data[7:3], scroll_t[4:0]};
            write_toggle_next = 1'b0;
            res.scroll_update = 1'b1;
          end
        end
        REG_ADDR: begin
          if (!write_toggle) begin
            scroll_t_next     = {1'b0, req.write_data[5:0], scroll_t[7:0]};
            write_toggle_next = 1'b1;
          end else begin
            scroll_t_next     = {scroll_t[14:8], req.write_data};
            vram_addr_next    = {1'b0, scroll_t[14:8], req.write_data};
            write_toggle_next = 1'b0;
          end
        end
        REG_DATA: begin
          if (region_ext) begin
            res.mem_access  = ACC_WRITE;
            res.mem_address = vram_addr[13:0];
          end else if (region_pal) begin
            palette_we = 1'b1;
          end else begin
            res.bad_address = 1'b1;
          end
          vram_addr_next = vram_addr + inc;
        end
        REG_DMA: begin
          dma_page_reg_next = req.write_data;
          res.dma_request   = 1'b1;
        end
        default: ;
      endcase
    end

    res.scroll_latch  = scroll_t_next;
    res.fine_scroll_x = fine_x_next;
    res.dma_page      = dma_page_reg_next;
    res.control_bits  = control_reg_next;
    res.mask_bits     = mask_reg_next;
  end

  // Request capture, sprite memory port and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req       <= in_data;
      oam_rdata <= sprite_mem[oam_pointer[OAM_AW-1:0]];
    end
    if (cmd.commit && sprite_we) sprite_mem[oam_pointer[OAM_AW-1:0]] <= req.write_data;
    if (cmd.commit) out_q <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_t     <= '0;
      vram_addr    <= '0;
      write_toggle <= 1'b0;
      fine_x       <= '0;
      control_reg  <= '0;
      mask_reg     <= '0;
      oam_pointer  <= '0;
      data_buffer  <= '0;
      dma_page_reg <= '0;
      oam_valid    <= '0;
      oam_rvalid   <= 1'b0;
      for (int i = 0; i < PALETTE_BYTES; i++) begin
        palette[i] <= vcrp_default_palette(5'(i));
      end
    end else begin
      if (cmd.load) oam_rvalid <= oam_valid[oam_pointer[OAM_AW-1:0]];
      if (cmd.commit) begin
        scroll_t     <= scroll_t_next;
        vram_addr    <= vram_addr_next;
        write_toggle <= write_toggle_next;
        fine_x       <= fine_x_next;
        control_reg  <= control_reg_next;
        mask_reg     <= mask_reg_next;
        oam_pointer  <= oam_pointer_next;
        data_buffer  <= data_buffer_next;
        dma_page_reg <= dma_page_reg_next;
        if (sprite_we) oam_valid[oam_pointer[OAM_AW-1:0]] <= 1'b1;
        if (palette_we) palette[pal_slot[PAL_AW-1:0]] <= req.write_data;
      end
    end
  end

  assign out_data = out_q;

  a_access_not_bad: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !(out_q.bad_address && (out_q.mem_access != ACC_NONE)))
    else $error("external access issued at unmapped address");

  a_scroll_clears_toggle: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && res.scroll_update) |=> !write_toggle)
    else $error("second scroll write left the toggle set");

  a_dma_from_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && res.dma_request) |-> (req.op == OP_WRITE))
    else $error("DMA request raised on a read");

endmodule

// ===== src/video_chip_register_port_core.sv =====
// Processor-side register port of a tile video chip. Each request on the
// input channel is one bus access (op 0 read, 1 write) to one of the eight
// chip registers (reg_index 0..7) or to the sprite DMA page (reg_index 8);
// each request yields exactly one result on the output channel, in order.
// The port holds the scroll latch, VRAM address, shared write toggle, fine
// X, control and mask bits, a 256-byte sprite memory with its pointer, a
// 32-entry mirrored palette (loaded with the default palette at reset) and
// the data-port read buffer. VRAM 0x0000..0x2FFF is external: a data-port
// access there is reported through mem_access/mem_address, and on a read
// mem_byte must carry the byte at that address with the same request.
// Palette reads return at once; unmapped addresses set bad_address. Each
// request is first captured while the sprite memory is read (a synchronous
// RAM port); then, once the result slot is free, state is updated and the
// result register loaded. A new request is taken once the previous one has
// been loaded into the result register, even while that result still waits
// to be taken. The sprite memory needs no clearing pass after reset:
// per-byte valid flags make unwritten bytes read as zero.
module video_chip_register_port_core
  import vcrp_pkg::*;
#(
  parameter int OAM_BYTES     = OAM_BYTES_DEF,
  parameter int PALETTE_BYTES = PALETTE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  vcrp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output vcrp_out_t out_data
);

  vcrp_cmd_t cmd;

  // Sequence each request: capture, then commit when the result slot frees
  vcrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Register file, memories and result register
  vcrp_datapath #(
    .OAM_BYTES     (OAM_BYTES),
    .PALETTE_BYTES (PALETTE_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ===== dv/video_chip_register_port_checker.sv =====
module video_chip_register_port_checker
  import vcrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  vcrp_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  vcrp_out_t out_data,
  output int        mismatches,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {ZONE_EXTERNAL, ZONE_PALETTE, ZONE_UNMAPPED} vram_zone_t;

  // Power-up palette contents, entry 0 in the low byte.
  localparam logic [255:0] PALETTE_AT_RESET = {
    8'h3C, 8'h38, 8'h02, 8'h0F, 8'h14, 8'h15, 8'h1C, 8'h0F,
    8'h3C, 8'h38, 8'h02, 8'h0F, 8'h14, 8'h15, 8'h1C, 8'h0F,
    8'h3F, 8'h3E, 8'h3D, 8'h0F, 8'h3B, 8'h3A, 8'h39, 8'h0F,
    8'h37, 8'h36, 8'h35, 8'h0F, 8'h33, 8'h32, 8'h31, 8'h0F
  };

  logic [14:0] latch_q;
  logic [15:0] vram_q;
  logic        toggle_q;
  logic [2:0]  fine_q;
  logic [7:0]  control_q;
  logic [3:0]  mask_q;
  logic [7:0]  oam_ptr_q;
  logic [7:0]  oam_q [OAM_BYTES_DEF];
  logic [7:0]  pal_q [PALETTE_BYTES_DEF];
  logic [7:0]  buffer_q;
  logic [7:0]  dma_q;

  vcrp_out_t bus_results_due [$];

  function automatic vram_zone_t zone_of(input logic [15:0] addr);
    if (addr < EXT_LIMIT) return ZONE_EXTERNAL;
    if (addr[15:8] == PALETTE_PAGE) return ZONE_PALETTE;
    return ZONE_UNMAPPED;
  endfunction

  // Backdrop entries of the sprite half fold onto the background half.
  function automatic logic [4:0] palette_entry(input logic [15:0] addr);
    logic [4:0] slot;
    slot = addr[4:0];
    if ((slot & 5'h13) == 5'h10) slot = slot & 5'h0F;
    return slot;
  endfunction

  // Apply one bus access to the shadow state and return what the port answers.
  function automatic vcrp_out_t bus_response(input vcrp_in_t req);
    vcrp_out_t  res;
    logic [15:0] stride;
    vram_zone_t zone;
    res = '0;
    stride = control_q[2] ? 16'd32 : 16'd1;
    zone = zone_of(vram_q);
    if (req.op == OP_READ) begin
      case (req.reg_index)
        REG_STATUS: begin
          res.read_data = {req.vblank_flag, req.hit_flag, req.overflow_flag, 5'd0};
          toggle_q = 1'b0;
        end
        REG_OAMDATA: res.read_data = oam_q[oam_ptr_q];
        REG_DATA: begin
          res.read_data = buffer_q;
          case (zone)
            ZONE_EXTERNAL: begin
              res.mem_access = ACC_READ;
              res.mem_address = vram_q[13:0];
              buffer_q = req.mem_byte;
            end
            ZONE_PALETTE: res.read_data = pal_q[palette_entry(vram_q)];
            default: res.bad_address = 1'b1;
          endcase
          vram_q = vram_q + stride;
        end
        default: ;
      endcase
    end else begin
      case (req.reg_index)
        REG_CONTROL: begin
          control_q = req.write_data;
          latch_q[11:10] = req.write_data[1:0];
        end
        REG_MASK: mask_q = req.write_data[4:1];
        REG_OAMADDR: oam_ptr_q = req.write_data;
        REG_OAMDATA: begin
          oam_q[oam_ptr_q] = req.write_data;
          oam_ptr_q = oam_ptr_q + 8'd1;
        end
        REG_SCROLL: begin
          if (!toggle_q) begin
            latch_q[4:0] = req.write_data[7:3];
            fine_q = req.write_data[2:0];
            toggle_q = 1'b1;
          end else begin
            latch_q[14:12] = req.write_data[2:0];
            latch_q[9:5] = req.write_data[7:3];
            toggle_q = 1'b0;
            res.scroll_update = 1'b1;
          end
        end
        REG_ADDR: begin
          if (!toggle_q) begin
            latch_q[14:8] = {1'b0, req.write_data[5:0]};
            toggle_q = 1'b1;
          end else begin
            latch_q[7:0] = req.write_data;
            vram_q = {1'b0, latch_q};
            toggle_q = 1'b0;
          end
        end
        REG_DATA: begin
          case (zone)
            ZONE_EXTERNAL: begin
              res.mem_access = ACC_WRITE;
              res.mem_address = vram_q[13:0];
            end
            ZONE_PALETTE: pal_q[palette_entry(vram_q)] = req.write_data;
            default: res.bad_address = 1'b1;
          endcase
          vram_q = vram_q + stride;
        end
        REG_DMA: begin
          dma_q = req.write_data;
          res.dma_request = 1'b1;
        end
        default: ;
      endcase
    end
    res.scroll_latch = latch_q;
    res.fine_scroll_x = fine_q;
    res.dma_page = dma_q;
    res.control_bits = control_q;
    res.mask_bits = mask_q;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    vcrp_out_t want;
    if (rst) begin
      latch_q = '0;
      vram_q = '0;
      toggle_q = 1'b0;
      fine_q = '0;
      control_q = '0;
      mask_q = '0;
      oam_ptr_q = '0;
      foreach (oam_q[i]) oam_q[i] = '0;
      foreach (pal_q[i]) pal_q[i] = PALETTE_AT_RESET[i*8 +: 8];
      buffer_q = '0;
      dma_q = '0;
      bus_results_due.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) bus_results_due.push_back(bus_response(in_data));
      if (out_valid && out_ready) begin
        if (bus_results_due.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = bus_results_due.pop_front();
          check_field("read_data", out_data.read_data, want.read_data);
          check_field("mem_access", out_data.mem_access, want.mem_access);
          check_field("mem_address", out_data.mem_address, want.mem_address);
          check_field("bad_address", out_data.bad_address, want.bad_address);
          check_field("scroll_latch", out_data.scroll_latch, want.scroll_latch);
          check_field("fine_scroll_x", out_data.fine_scroll_x, want.fine_scroll_x);
          check_field("scroll_update", out_data.scroll_update, want.scroll_update);
          check_field("dma_request", out_data.dma_request, want.dma_request);
          check_field("dma_page", out_data.dma_page, want.dma_page);
          check_field("control_bits", out_data.control_bits, want.control_bits);
          check_field("mask_bits", out_data.mask_bits, want.mask_bits);
        end
      end
    end
    pending <= bus_results_due.size();
  end

endmodule

// ===== dv/video_chip_register_port_core_tb.sv =====
module video_chip_register_port_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vcrp_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  vcrp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  vcrp_out_t out_data;

  int mismatches;
  int pending;

  // Sender burst bookkeeping and receiver stall pattern state.
  int unsigned burst_left = 0;
  int unsigned requests_sent = 0;
  int unsigned ready_pct = 100;
  int unsigned stretch_left = 0;

  always #2 clk = ~clk;

  video_chip_register_port_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  video_chip_register_port_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Receiver: pick a readiness level for a stretch of cycles, then toss a
  // coin each cycle. Full-rate stretches give runs with no stalls at all.
  always @(posedge clk) begin
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(64, 8);
      case ($urandom_range(3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 10;
      endcase
    end
    stretch_left--;
    out_ready <= ($urandom_range(99) < ready_pct);
  end

  // Present one request and hold it until the port takes it. At the start
  // of each burst, drop valid for a random gap first; a zero gap keeps valid
  // high so the new request follows back to back.
  task automatic send_request(input logic op, input logic [3:0] idx,
                              input logic [7:0] data, input logic [7:0] mbyte,
                              input logic [2:0] flags);
    vcrp_in_t    req;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(20, 5) : $urandom_range(3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(200, 50) : $urandom_range(12, 1);
    end
    burst_left--;
    req.op = op;
    req.reg_index = idx;
    req.write_data = data;
    req.mem_byte = mbyte;
    req.hit_flag = flags[2];
    req.overflow_flag = flags[1];
    req.vblank_flag = flags[0];
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic bus_write(input logic [3:0] idx, input logic [7:0] data);
    send_request(OP_WRITE, idx, data, 8'($urandom), 3'($urandom));
  endtask

  task automatic bus_read(input logic [3:0] idx);
    send_request(OP_READ, idx, 8'($urandom), 8'($urandom), 3'($urandom));
  endtask

  // One random bus sequence. Most are well-formed register programming with
  // random content; the rest is raw noise over the whole register index.
  task automatic random_sequence();
    int unsigned pick;
    logic [7:0]  hi;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // Point the address register somewhere, then stream data accesses.
      if ($urandom_range(9) != 0) bus_read(REG_STATUS);
      case ($urandom_range(2))
        0: hi = 8'h3F;
        1: hi = 8'($urandom_range(8'h2F));
        default: hi = 8'($urandom);
      endcase
      bus_write(REG_ADDR, hi);
      bus_write(REG_ADDR, 8'($urandom));
      repeat ($urandom_range(8, 1))
        send_request($urandom_range(1) ? OP_WRITE : OP_READ, REG_DATA,
                     8'($urandom), 8'($urandom), 3'($urandom));
    end else if (pick < 50) begin
      bus_read(REG_STATUS);
      bus_write(REG_SCROLL, 8'($urandom));
      bus_write(REG_SCROLL, 8'($urandom));
    end else if (pick < 65) begin
      bus_write(REG_OAMADDR, 8'($urandom));
      repeat ($urandom_range(6, 1)) begin
        if ($urandom_range(1)) bus_write(REG_OAMDATA, 8'($urandom));
        else bus_read(REG_OAMDATA);
      end
    end else if (pick < 73) begin
      bus_write(REG_CONTROL, 8'($urandom));
    end else if (pick < 80) begin
      bus_write($urandom_range(1) ? REG_MASK : REG_DMA, 8'($urandom));
    end else if (pick < 85) begin
      bus_read(REG_STATUS);
    end else begin
      send_request(1'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 3'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Status read with every flag set, then all-ones writes to control and mask.
    send_request(OP_READ, REG_STATUS, 8'h00, 8'h00, 3'b111);
    bus_write(REG_CONTROL, 8'hFF);
    bus_write(REG_MASK, 8'hFF);
    // Scroll pair: the second write pulses the update.
    bus_write(REG_SCROLL, 8'hFF);
    bus_write(REG_SCROLL, 8'h00);
    send_request(OP_READ, REG_STATUS, 8'hFF, 8'hFF, 3'b000);
    // Palette write through the sprite backdrop mirror.
    bus_write(REG_ADDR, 8'h3F);
    bus_write(REG_ADDR, 8'h10);
    bus_write(REG_DATA, 8'hAB);
    // Upper address bits are dropped; read the mirrored entry straight back.
    bus_write(REG_ADDR, 8'hFF);
    bus_write(REG_ADDR, 8'h00);
    bus_read(REG_DATA);
    // Last palette byte, then the step into the unmapped space above it.
    bus_write(REG_ADDR, 8'h3F);
    bus_write(REG_ADDR, 8'hFF);
    bus_write(REG_DATA, 8'h5A);
    bus_read(REG_DATA);
    // Buffered reads from external memory: old buffer out, new byte in.
    bus_write(REG_ADDR, 8'h00);
    bus_write(REG_ADDR, 8'h00);
    send_request(OP_READ, REG_DATA, 8'h00, 8'hC3, 3'b000);
    send_request(OP_READ, REG_DATA, 8'h00, 8'h00, 3'b000);
    // Sprite pointer wraps after the write at its top entry.
    bus_write(REG_OAMADDR, 8'hFF);
    bus_write(REG_OAMDATA, 8'h77);
    bus_read(REG_OAMDATA);
    bus_write(REG_DMA, 8'hFF);
    // Indexes past the DMA page do nothing.
    bus_write(4'hF, 8'hFF);
    bus_read(4'd9);

    while (requests_sent < 400) random_sequence();

    // Walk the VRAM address by 32 from the top of the palette well into the
    // unmapped space above it.
    bus_write(REG_CONTROL, 8'($urandom) | 8'h04);
    bus_read(REG_STATUS);
    bus_write(REG_ADDR, 8'h3F);
    bus_write(REG_ADDR, 8'hE0);
    repeat (300)
      send_request($urandom_range(1) ? OP_WRITE : OP_READ, REG_DATA,
                   8'($urandom), 8'($urandom), 3'($urandom));

    while (requests_sent < 1200) random_sequence();

    // Release the input channel and drain the outstanding results.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
